// ===== hdl/ss_pkg.sv =====
`default_nettype none
package ss_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_GAP_START,
    S_GAP_CHK,
    S_RD,
    S_CMP,
    S_SWAP,
    S_ADV,
    S_EMIT_RD,
    S_EMIT_OUT
  } ss_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic gap_init;
    logic outer_init;
    logic rd_cmp;
    logic wr_lo;
    logic swap_hi;
    logic outer_inc;
    logic gap_halve;
    logic emit_init;
    logic rd_emit;
    logic emit_out;
  } ss_cmd_t;

  typedef struct packed {
    logic will_fill;
    logic count_zero;
    logic gap_zero;
    logic greater;
    logic lo_ge_gap;
    logic outer_last;
    logic out_free;
  } ss_sts_t;

endpackage
`default_nettype wire

// ===== hdl/ss_ctrl.sv =====
`default_nettype none
module ss_ctrl
  import ss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last_item,
  input  wire ss_sts_t   sts,
  output ss_cmd_t        cmd,
  output ss_state_t      state
);

  ss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // list ends on the flag or when this item fills the store
          if (in_last_item || sts.will_fill) state_nxt = S_GAP_START;
        end
      end
      S_GAP_START: begin
        cmd.gap_init = 1'b1;
        state_nxt    = S_GAP_CHK;
      end
      S_GAP_CHK: begin
        if (sts.gap_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          cmd.outer_init = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_cmp = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.wr_lo = 1'b1;
          state_nxt = S_SWAP;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_SWAP: begin
        cmd.swap_hi = 1'b1;
        state_nxt   = sts.lo_ge_gap ? S_RD : S_ADV;
      end
      S_ADV: begin
        if (sts.outer_last) begin
          cmd.gap_halve = 1'b1;
          state_nxt     = S_GAP_CHK;
        end else begin
          cmd.outer_inc = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.emit_out = 1'b1;
          state_nxt    = sts.outer_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

// ===== hdl/ss_dpath.sv =====
`default_nettype none
module ss_dpath
  import ss_pkg::*;
#(
  parameter int MaxItems = MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ss_cmd_t                  cmd,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     out_ready,
  output ss_sts_t                       sts,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_last_result
);

  localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int CW = $clog2(MaxItems + 1);

  logic signed [DATA_W-1:0] mem [MaxItems];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic [CW-1:0] outer_r, outer_nxt;
  logic [CW-1:0] inner_r, inner_nxt;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  logic [CW-1:0]            lo;
  logic [CW-1:0]            outer_inc;
  logic [AW-1:0]            rd_addr_a;
  logic                     we;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign lo        = inner_r - gap_r;
  assign outer_inc = outer_r + CW'(1);
  assign rd_addr_a = cmd.rd_emit ? outer_r[AW-1:0] : lo[AW-1:0];

  assign sts.will_fill  = (count_r == CW'(MaxItems - 1));
  assign sts.count_zero = (count_r == '0);
  assign sts.gap_zero   = (gap_r == '0);
  assign sts.greater    = (rd_a_r > rd_b_r);
  assign sts.lo_ge_gap  = (lo >= gap_r);
  assign sts.outer_last = (outer_inc == count_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // one write port: load, then the two halves of a swap on separate cycles
  always_comb begin
    we      = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_value;
    if (cmd.load) begin
      we = 1'b1;
    end else if (cmd.wr_lo) begin
      we      = 1'b1;
      wr_addr = lo[AW-1:0];
      wr_data = rd_b_r;
    end else if (cmd.swap_hi) begin
      we      = 1'b1;
      wr_addr = inner_r[AW-1:0];
      wr_data = rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (cmd.rd_cmp || cmd.rd_emit) rd_a_r <= mem[rd_addr_a];
    if (cmd.rd_cmp) rd_b_r <= mem[inner_r[AW-1:0]];
  end

  always_comb begin
    count_nxt     = count_r;
    gap_nxt       = gap_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) count_nxt = count_r + CW'(1);
    if (cmd.gap_init) gap_nxt = count_r >> 1;
    if (cmd.gap_halve) gap_nxt = gap_r >> 1;
    if (cmd.outer_init) begin
      outer_nxt = gap_r;
      inner_nxt = gap_r;
    end
    if (cmd.outer_inc) begin
      outer_nxt = outer_inc;
      inner_nxt = outer_inc;
    end
    if (cmd.swap_hi) inner_nxt = lo;
    if (cmd.emit_init) outer_nxt = '0;
    if (cmd.emit_out) begin
      outer_nxt     = outer_inc;
      out_valid_nxt = 1'b1;
      if (sts.outer_last) count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      gap_r       <= '0;
      outer_r     <= '0;
      inner_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      gap_r       <= gap_nxt;
      outer_r     <= outer_nxt;
      inner_r     <= inner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_out) begin
      out_value_r <= rd_a_r;
      out_last_r  <= sts.outer_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_result  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/shell_sorter.sv =====
`default_nettype none
// Shell sorter: accepts a list of signed 32-bit values, one transaction per cycle, ending
// with in_last_item or when MaxItems values are held, then sorts it ascending (gap starts
// at count/2 and halves to 1, gapped insertion by backward compare-and-swap) and emits the
// values in order with out_last_result on the final one. Sorting takes per compare a read,
// the compare, then an advance or the second swap write, set by the single write port of
// the element memory, plus an advance when a run of swaps reaches the front of its gap,
// a gap check per gap, and a start step and closing gap check; each value is emitted by a
// read, then an output step that waits for a free output slot. Equal values may reorder.
// in_ready is low from the last loaded value until the last result is registered; that
// result may still wait on out_ready while the next list loads.
module shell_sorter
  import ss_pkg::*;
#(
  parameter int MaxItems = MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_last_result
);

  ss_cmd_t   cmd;
  ss_sts_t   sts;
  ss_state_t state;

  ss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .sts          (sts),
    .cmd          (cmd),
    .state        (state)
  );

  ss_dpath #(
    .MaxItems (MaxItems)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .out_ready        (out_ready),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result)
  );

  assign in_ready = cmd.in_ready;

  // outside loading there is always a non-empty list
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state != S_LOAD) |-> !sts.count_zero)
    else $error("sort or emit with empty list");

  // a compare pass never runs with a zero gap
  a_gap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_RD) |-> !sts.gap_zero)
    else $error("compare issued with zero gap");

  // first swap write is always followed by the second
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_lo |=> cmd.swap_hi)
    else $error("swap left half done");

  // a result is registered only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== tb/tb_shell_sorter.sv =====
`timescale 1ns / 1ps
module tb_shell_sorter;
  import ss_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    bit                       drain;  // wait for all results before offering
    bit                       quiet;  // no idle cycles before this transaction
  } feed_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sorted_item_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last_item = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_last_result;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  feed_item_t               feed_q[$];
  sorted_item_t             sorted_q[$];
  logic signed [DATA_W-1:0] open_list[$];
  int                       err_cnt = 0;
  int                       rcv_cnt = 0;
  int                       item_cnt = 0;
  bit                       offering = 1'b0;

  shell_sorter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result)
  );

  always #5 clk = ~clk;

  // Shell sort with halving gaps over the collected list, then queue the results.
  function automatic void sort_open_list();
    int n;
    int gap;
    int j;
    logic signed [DATA_W-1:0] t;
    sorted_item_t r;
    n = open_list.size();
    gap = n / 2;
    while (gap > 0) begin
      for (int i = gap; i < n; i++) begin
        j = i;
        while (j >= gap && open_list[j-gap] > open_list[j]) begin
          t = open_list[j-gap];
          open_list[j-gap] = open_list[j];
          open_list[j] = t;
          j = j - gap;
        end
      end
      gap = gap / 2;
    end
    for (int k = 0; k < n; k++) begin
      r.value = open_list[k];
      r.last = (k == n - 1);
      sorted_q.push_back(r);
    end
    open_list.delete();
  endfunction

  function automatic void push_item(logic signed [DATA_W-1:0] v, logic l, bit d, bit q);
    feed_item_t it;
    it.value = v;
    it.last = l;
    it.drain = d;
    it.quiet = q;
    feed_q.push_back(it);
    item_cnt++;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(int kind);
    logic signed [DATA_W-1:0] v;
    case (kind)
      0: v = $urandom_range(0, 7) - 4;  // heavy duplicates
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void push_list(int len, bit d, bit q);
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      push_item(pick_value(kind), i == len - 1, d && i == 0, q);
  endfunction

  // Driver
  always @(negedge clk) begin
    feed_item_t cur;
    int tx_wait;
    if (rst_n) begin
      if (in_fire) begin
        offering = 1'b0;
        tx_wait = (feed_q.size() > 0 && feed_q[0].quiet) ? 0 : $urandom_range(0, 9);
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (feed_q.size() > 0 && !(feed_q[0].drain && sorted_q.size() > 0)) begin
          cur = feed_q.pop_front();
          in_value <= cur.value;
          in_last_item <= cur.last;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    int rx_wait;
    int hold_cnt;
    bit hold_done;
    bit rx_quiet;
    if (rst_n) begin
      if (!hold_done && rcv_cnt >= 100) begin
        hold_cnt = 400;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (out_fire) begin
        if ($urandom_range(0, 31) == 0)
          rx_quiet = ~rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
        out_ready <= (rx_wait == 0);
        if (rx_wait > 0)
          rx_wait--;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    sorted_item_t exp_r;
    if (!rst_n) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        open_list.push_back(in_value);
        if (in_last_item || open_list.size() == MAX_ITEMS_DEF)
          sort_open_list();
      end
      if (out_valid && out_ready) begin
        rcv_cnt++;
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result transaction value=%0d last=%0b",
                   $time, out_sorted_value, out_last_result);
          err_cnt++;
        end else begin
          exp_r = sorted_q.pop_front();
          if (out_sorted_value !== exp_r.value) begin
            $display("%0t: sorted_value mismatch expected=%0d actual=%0d",
                     $time, exp_r.value, out_sorted_value);
            err_cnt++;
          end
          if (out_last_result !== exp_r.last) begin
            $display("%0t: last_result mismatch expected=%0b actual=%0b",
                     $time, exp_r.last, out_last_result);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    // single-element list at the most negative value
    push_item(32'sh8000_0000, 1'b1, 1'b0, 1'b0);
    // field extremes, back to back
    push_item(32'sh7fff_ffff, 1'b0, 1'b0, 1'b1);
    push_item(32'sh8000_0000, 1'b0, 1'b0, 1'b1);
    push_item(0, 1'b0, 1'b0, 1'b1);
    push_item(-1, 1'b0, 1'b0, 1'b1);
    push_item(1, 1'b1, 1'b0, 1'b1);
    // equal values repeated within one list
    push_item(7, 1'b0, 1'b0, 1'b0);
    push_item(7, 1'b0, 1'b0, 1'b0);
    push_item(-3, 1'b0, 1'b0, 1'b0);
    push_item(7, 1'b1, 1'b0, 1'b0);
    // alternating bit patterns, descending pair
    push_item(32'sh5555_5555, 1'b0, 1'b0, 1'b0);
    push_item(32'shAAAA_AAAA, 1'b1, 1'b0, 1'b0);
    // reverse-ordered short list
    for (int i = 0; i < 8; i++)
      push_item(100 - 10 * i, i == 7, 1'b0, 1'b0);

    // full store ended by the flag, then one that overflows into a new list
    push_list(64, 1'b1, 1'b0);
    push_list(66, 1'b0, 1'b1);
    for (int lst = 0; item_cnt < 280; lst++) begin
      push_list(($urandom_range(0, 14) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 12),
                lst == 3 || $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (feed_q.size() == 0 && !offering);
    wait (sorted_q.size() == 0 && open_list.size() == 0);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("shell_sorter regression: pass");
    end else begin
      $display("shell_sorter regression: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("shell_sorter regression: fail");
    $finish;
  end

endmodule
